// ===== rtl/core/sci_pkg.sv =====
// Shared definitions for the sine/cosine quarter-wave lookup block.
// Holds the default sizes, the request kind codes and the result format.
// No dependencies.
package sci_pkg;

	localparam int SCI_TABLE_ENTRIES = 2048;
	localparam int SCI_PHASE_BITS    = 20;
	localparam int SCI_QUEUE_DEPTH   = 4;

	// Signed Q1.16 result
	localparam int                    SCI_RESULT_W = 18;
	localparam logic [SCI_RESULT_W-1:0] SCI_ONE_Q16  = 18'd65536;

	typedef enum logic {
		KIND_SINE   = 1'b0,
		KIND_COSINE = 1'b1
	} kind_t;

endpackage

// ===== rtl/core/sci_front.sv =====
// Front end of the sine/cosine lookup: folds the phase onto a quarter wave
// and splits it into a table index and an interpolation fraction.
// Depends on sci_pkg.
module sci_front #(
	parameter int TABLE_ENTRIES = 2048,
	parameter int PHASE_BITS    = 20,
	localparam int IDX_W   = $clog2(TABLE_ENTRIES + 1),
	localparam int ENTRY_W = 1 + IDX_W + PHASE_BITS
) (
	input  sci_pkg::kind_t        kind,
	input  logic [PHASE_BITS:0]   phase,
	output logic [ENTRY_W-1:0]    entry
);
	import sci_pkg::*;

	localparam int                S_W  = PHASE_BITS + $clog2(2 * TABLE_ENTRIES) + 1;
	localparam logic [PHASE_BITS:0] ONE  = (PHASE_BITS + 1)'(1) << PHASE_BITS;
	localparam logic [PHASE_BITS:0] HALF = (PHASE_BITS + 1)'(1) << (PHASE_BITS - 1);

	logic [PHASE_BITS:0]   p_sat;
	logic [PHASE_BITS:0]   folded;
	logic                  neg;
	logic [S_W-1:0]        scaled;
	logic [IDX_W-1:0]      idx;
	logic [PHASE_BITS-1:0] frac;

	always_comb begin
		p_sat = (phase > ONE) ? ONE : phase;
		neg   = 1'b0;
		if (kind == KIND_SINE) begin
			folded = (p_sat < HALF) ? p_sat : ONE - p_sat;
		end else if (p_sat < HALF) begin
			folded = HALF - p_sat;
		end else begin
			folded = p_sat - HALF;
			neg    = 1'b1;
		end
		// Folded phase is at most one half, so it fits in PHASE_BITS bits.
		scaled = S_W'(folded[PHASE_BITS-1:0]) * S_W'(2 * TABLE_ENTRIES);
		idx    = scaled[PHASE_BITS +: IDX_W];
		frac   = scaled[PHASE_BITS-1:0];
	end

	assign entry = {neg, idx, frac};

endmodule

// ===== rtl/core/sci_queue.sv =====
// Short first-in first-out queue between the front and back of the lookup.
// Register based, one write and one read port. Depends on sci_pkg only for
// the house import convention.
module sci_queue #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             not_empty
);
	import sci_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/sci_back.sv =====
// Back end of the sine/cosine lookup: quarter-sine ROM read, interpolation
// multiply and final sign, in three stages that stall together.
// Depends on sci_pkg.
module sci_back #(
	parameter int TABLE_ENTRIES = 2048,
	parameter int PHASE_BITS    = 20,
	localparam int IDX_W   = $clog2(TABLE_ENTRIES + 1),
	localparam int ENTRY_W = 1 + IDX_W + PHASE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ENTRY_W-1:0]                head,
	input  logic                              head_valid,
	output logic                              pop,
	output logic                              m_valid,
	input  logic                              m_ready,
	output logic [sci_pkg::SCI_RESULT_W-1:0]  result
);
	import sci_pkg::*;

	localparam int         ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int         MAG_W  = 17;
	localparam int         PROD_W = MAG_W + PHASE_BITS;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	// Angle step between entries is pi/2 over the table length, as a whole
	// part and a remainder so that every entry's angle is an exact floor.
	localparam logic [63:0] ROM_DEN = 64'(2 * TABLE_ENTRIES);
	localparam logic [63:0] ROM_Q   = PI_Q60 / ROM_DEN;
	localparam logic [63:0] ROM_R   = PI_Q60 % ROM_DEN;

	// (a*b) >> 60, exact floor
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Floor of num / den by restoring division, one quotient bit per pass.
	function automatic logic [63:0] divide_u64(input logic [63:0] num, input logic [15:0] den);
		logic [63:0] quo;
		logic [16:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[15:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Taylor series for sin(x), x in Q60 within [0, pi/2]
	function automatic logic [63:0] sine_q60(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [15:0] div;
		int unsigned k;
		x2   = mul_q60(x, x);
		term = x;
		sum  = x;
		for (k = 1; k < 24 && term != 64'd0; k++) begin
			div  = 16'((2 * k) * (2 * k + 1));
			term = divide_u64(mul_q60(term, x2), div);
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	logic [15:0] sine_rom_q [TABLE_ENTRIES];

	// The table is filled once at start-up and never written afterwards.
	initial begin
		logic [63:0] x;
		logic [63:0] rem;
		logic [63:0] v;
		x   = '0;
		rem = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			v = (sine_q60(x) + (64'd1 << 43)) >> 44;
			sine_rom_q[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
			x   = x + ROM_Q;
			rem = rem + ROM_R;
			if (rem >= ROM_DEN) begin
				rem = rem - ROM_DEN;
				x   = x + 64'd1;
			end
		end
	end

	logic                  advance;
	logic                  head_neg;
	logic [IDX_W-1:0]      head_idx;
	logic [PHASE_BITS-1:0] head_frac;
	logic [IDX_W:0]        next_idx;
	logic [ADDR_W-1:0]     addr_a;
	logic [ADDR_W-1:0]     addr_b;

	logic                  valid_s1;
	logic [15:0]           a_s1;
	logic [15:0]           b_s1;
	logic [PHASE_BITS-1:0] frac_s1;
	logic                  neg_s1;
	logic                  last_s1;
	logic                  beyond_s1;

	logic signed [MAG_W:0] diff;
	logic [MAG_W-1:0]      diff_mag;

	logic                  valid_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic                  dneg_s2;
	logic [15:0]           a_s2;
	logic                  neg_s2;
	logic                  beyond_s2;

	logic [MAG_W-1:0]        step;
	logic [SCI_RESULT_W-1:0] mag;
	logic [SCI_RESULT_W-1:0] res_next;

	logic                    valid_s3;
	logic [SCI_RESULT_W-1:0] res_s3;

	// All three stages move together whenever the output stage is empty or its word is taken.
	assign advance = !valid_s3 || m_ready;
	assign pop     = advance && head_valid;

	assign {head_neg, head_idx, head_frac} = head;
	assign next_idx = {1'b0, head_idx} + 1'b1;

	// Addresses past the table are steered to entry zero; those reads are unused.
	always_comb begin
		addr_a = (head_idx >= IDX_W'(TABLE_ENTRIES)) ? '0 : head_idx[ADDR_W-1:0];
		addr_b = (next_idx >= (IDX_W + 1)'(TABLE_ENTRIES)) ? '0 : next_idx[ADDR_W-1:0];
	end

	always_comb begin
		diff     = (last_s1 ? (MAG_W + 1)'(65536) : (MAG_W + 1)'(b_s1)) - (MAG_W + 1)'(a_s1);
		diff_mag = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
	end

	always_comb begin
		step = prod_s2[PHASE_BITS +: MAG_W];
		if (beyond_s2) begin
			mag = SCI_ONE_Q16;
		end else if (dneg_s2) begin
			mag = SCI_RESULT_W'(a_s2) - SCI_RESULT_W'(step);
		end else begin
			mag = SCI_RESULT_W'(a_s2) + SCI_RESULT_W'(step);
		end
		res_next = neg_s2 ? -mag : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1      <= sine_rom_q[addr_a];
			b_s1      <= sine_rom_q[addr_b];
			frac_s1   <= head_frac;
			neg_s1    <= head_neg;
			last_s1   <= (head_idx == IDX_W'(TABLE_ENTRIES - 1));
			beyond_s1 <= (head_idx >= IDX_W'(TABLE_ENTRIES));

			prod_s2   <= PROD_W'(diff_mag) * PROD_W'(frac_s1);
			dneg_s2   <= diff[MAG_W];
			a_s2      <= a_s1;
			neg_s2    <= neg_s1;
			beyond_s2 <= beyond_s1;

			res_s3    <= res_next;
		end
	end

	assign m_valid = valid_s3;
	assign result  = res_s3;

endmodule

// ===== rtl/core/sine_cosine_interp_lookup.sv =====
// Sine/cosine of pi*phase from a quarter-wave table with linear interpolation.
// Throughput: one word per cycle; a word is taken while the queue has room.
// A word passes through the queue write, then the ROM read, multiply and sign
// registers in that order, and waits in them while the output is stalled.
// Reset clears the queue pointers and pipeline valid bits; the ROM is constant.
module sine_cosine_interp_lookup #(
	parameter int TABLE_ENTRIES = sci_pkg::SCI_TABLE_ENTRIES,
	parameter int PHASE_BITS    = sci_pkg::SCI_PHASE_BITS,
	localparam int IN_TDATA_W  = ((PHASE_BITS + 8) / 8) * 8,
	localparam int OUT_TDATA_W = ((sci_pkg::SCI_RESULT_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // phase (PHASE_BITS+1 bits), zero pad
	input  logic                   s_tuser,   // kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // result (18 bits, signed), zero pad
);
	import sci_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_W = 1 + IDX_W + PHASE_BITS;

	logic [ENTRY_W-1:0]      entry;
	logic [ENTRY_W-1:0]      head;
	logic                    queue_full;
	logic                    head_valid;
	logic                    pop;
	logic [SCI_RESULT_W-1:0] result;

	sci_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.PHASE_BITS   (PHASE_BITS)
	) u_front (
		.kind (kind_t'(s_tuser)),
		.phase(s_tdata[PHASE_BITS:0]),
		.entry(entry)
	);

	sci_queue #(
		.DEPTH(SCI_QUEUE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid),
		.push_data(entry),
		.pop      (pop),
		.head     (head),
		.full     (queue_full),
		.not_empty(head_valid)
	);

	sci_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.PHASE_BITS   (PHASE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.result    (result)
	);

	assign s_tready = !queue_full;
	assign m_tdata  = OUT_TDATA_W'(result);

endmodule

// ===== test/testbench.sv =====
// Testbench for sine_cosine_interp_lookup: drives phase words with random gaps and
// checks every result word against a bit-exact quarter-wave table model built here.
// Depends on sci_pkg and the sine_cosine_interp_lookup RTL.
`timescale 1ns / 100ps

module testbench;
	import sci_pkg::*;

	localparam int PHASE_W   = SCI_PHASE_BITS + 1;
	localparam int IN_W      = ((SCI_PHASE_BITS + 8) / 8) * 8;
	localparam int OUT_W     = ((SCI_RESULT_W + 7) / 8) * 8;
	localparam longint ONE   = longint'(1) << SCI_PHASE_BITS;
	localparam longint HALF  = ONE >> 1;
	localparam longint PHASE_MAX = (longint'(1) << PHASE_W) - 1;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam int RANDOM_ITEMS = 1600;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;    // phase (21 bits), zero pad
	logic             s_tuser;    // kind
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;    // result (18 bits, signed), zero pad

	logic [15:0]             sine_table [SCI_TABLE_ENTRIES];
	logic [SCI_RESULT_W-1:0] expected_results [$];
	int                      error_count;
	bit                      no_gaps;

	sine_cosine_interp_lookup uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// Exact floor of (a*b) / 2^60.
	function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	// Taylor series of sin(x) in Q60 for x in [0, pi/2].
	function automatic logic [63:0] q60_sine(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2   = q60_mul(x, x);
		term = x;
		sum  = x;
		for (int k = 1; k < 24 && term != 0; k++) begin
			term = q60_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	task automatic build_sine_table();
		logic [63:0] den;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] v;
		den = 64'(2 * SCI_TABLE_ENTRIES);
		q   = PI_Q60 / den;
		r   = PI_Q60 % den;
		for (int i = 0; i < SCI_TABLE_ENTRIES; i++) begin
			x = q * 64'(i) + (r * 64'(i)) / den;
			v = (q60_sine(x) + (64'd1 << 43)) >> 44;
			if (v > 64'd65535)
				v = 64'd65535;
			sine_table[i] = v[15:0];
		end
	endtask

	function automatic logic [SCI_RESULT_W-1:0] predict_trig(input kind_t kind,
			input logic [PHASE_W-1:0] phase);
		longint p;
		longint f;
		longint s;
		longint idx;
		longint frac;
		longint a;
		longint b;
		longint d;
		longint step;
		longint mag;
		bit     negate;
		p      = longint'(phase);
		negate = 1'b0;
		if (p > ONE)
			p = ONE;
		if (kind == KIND_SINE) begin
			f = (p < HALF) ? p : ONE - p;
		end else if (p < HALF) begin
			f = HALF - p;
		end else begin
			f      = p - HALF;
			negate = 1'b1;
		end
		s    = f * 2 * SCI_TABLE_ENTRIES;
		idx  = s >> SCI_PHASE_BITS;
		frac = s & (ONE - 1);
		if (idx >= SCI_TABLE_ENTRIES) begin
			mag = 65536;
		end else begin
			a = longint'(sine_table[idx]);
			// The step past the last entry runs towards exactly 1.0.
			b = (idx + 1 < SCI_TABLE_ENTRIES) ? longint'(sine_table[idx + 1]) : 65536;
			d = b - a;
			if (d >= 0)
				step = (d * frac) >>> SCI_PHASE_BITS;
			else
				step = -(((-d) * frac) >>> SCI_PHASE_BITS);
			mag = a + step;
		end
		if (negate)
			mag = -mag;
		return mag[SCI_RESULT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [SCI_RESULT_W-1:0] want,
			input logic [SCI_RESULT_W-1:0] got);
		error_count++;
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what,
			$signed(want), $signed(got));
	endtask

	// Every accepted request word gets its expected result at the accepting edge.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			expected_results.push_back(predict_trig(kind_t'(s_tuser), s_tdata[PHASE_W-1:0]));
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0)
				report_mismatch("unexpected result word", '0, m_tdata[SCI_RESULT_W-1:0]);
			else if (m_tdata[SCI_RESULT_W-1:0] !== expected_results[0])
				report_mismatch("result", expected_results.pop_front(),
					m_tdata[SCI_RESULT_W-1:0]);
			else
				void'(expected_results.pop_front());
		end
	end

	// Receiver: after each result word, hold off for a random number of cycles.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				stall = no_gaps ? 0 : $urandom_range(0, 8);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Called at a rising edge; returns at the edge that accepts the word.
	task automatic send_word(input kind_t kind, input longint phase);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_W'(phase[PHASE_W-1:0]);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of the phase, both fold points, the last table entry,
	// the index past the table and phases above one, for both kinds.
	task automatic test_directed_points();
		longint points [12];
		points = '{0, 1, 255, 256, HALF - 1, HALF, HALF + 1, ONE - 1, ONE, ONE + 1,
			PHASE_MAX, 64'h0AAAAA};
		foreach (points[i]) begin
			send_word(KIND_SINE, points[i]);
			send_word(KIND_COSINE, points[i]);
		end
	endtask

	function automatic longint random_phase();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return longint'($urandom_range(0, int'(ONE)));
			6: return HALF - 512 + longint'($urandom_range(0, 1024));
			7: return longint'($urandom_range(int'(ONE), int'(PHASE_MAX)));
			8: return longint'($urandom_range(0, int'(PHASE_MAX)));
			default: begin
				// Near the ends of the range, where the cosine fold lands on the last entry.
				if ($urandom_range(0, 1))
					return longint'($urandom_range(0, 600));
				else
					return ONE - longint'($urandom_range(0, 600));
			end
		endcase
	endfunction

	task automatic test_random_sweep();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_gaps = ((i / 150) % 4 == 3);
			send_word(kind_t'($urandom_range(0, 1)), random_phase());
			if (i % 400 == 399)
				wait_for_drain();
		end
		no_gaps = 1'b0;
	endtask

	// Back-to-back words with both sides busy, then a full drain before more.
	task automatic test_drain_pause();
		no_gaps = 1'b1;
		for (int i = 0; i < 20; i++)
			send_word(kind_t'(i % 2), longint'($urandom_range(0, int'(ONE))));
		wait_for_drain();
		for (int i = 0; i < 20; i++)
			send_word(kind_t'($urandom_range(0, 1)), random_phase());
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		error_count = 0;
		no_gaps     = 1'b0;
		build_sine_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_points();
		test_random_sweep();
		test_drain_pause();

		wait_for_drain();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sci_pkg.sv
rtl/core/sci_front.sv
rtl/core/sci_queue.sv
rtl/core/sci_back.sv
rtl/core/sine_cosine_interp_lookup.sv
test/testbench.sv
